>>> hdl/crtt_pkg.sv
// ----------------------------------------------------------------------------
// crtt_pkg
// Shared types and constants for the connection reference translation table.
// ----------------------------------------------------------------------------
package crtt_pkg;

    localparam int REF_W   = 24;
    localparam int STAMP_W = 32;

    localparam logic [REF_W-1:0] REF_RESERVED    = 24'hFFFFFF;
    localparam logic [REF_W-1:0] REF_START_RESET = 24'h050000;
    localparam logic [1:0]       WRAP_LIMIT      = 2'd2;

    // opcodes
    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_UPDATE   = 3'd1;
    localparam logic [2:0] OP_REMOVE   = 3'd2;
    localparam logic [2:0] OP_TO_OWNER = 3'd3;
    localparam logic [2:0] OP_TO_CORE  = 3'd4;
    localparam logic [2:0] OP_FIND     = 3'd5;

    // status codes
    localparam logic [2:0] ST_CREATED   = 3'd0;
    localparam logic [2:0] ST_REUSED    = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_MISSING   = 3'd4;
    localparam logic [2:0] ST_NO_REF    = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_SCAN,
        FSM_DECIDE,
        FSM_UPD
    } fsm_t;

    typedef enum logic [1:0] {
        KEY_REAL,
        KEY_PATCHED,
        KEY_REMOTE
    } key_kind_t;

endpackage

>>> hdl/crtt_slot_ram.sv
// ----------------------------------------------------------------------------
// crtt_slot_ram
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crtt_slot_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 113
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/connection_reference_translation_table_core.sv
// ----------------------------------------------------------------------------
// connection_reference_translation_table_core
// Maps owner real references to unique patched references; slot table in RAM.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake              | word
//  ----------+-----------+------------------------+------------------------------
//  command   | in        | start & !busy          | opcode, owner_id, entry_index,
//            |           |                        | src_present/ref, dest_present/ref
//  result    | out       | done (one-cycle pulse) | status, hit_index, ref_out,
//            |           |                        | ref_rewritten
//  config    | in        | ref_start_we           | ref_start
//
//  Steps: a command missing a reference answers straight from idle; update
//  remote does one RAM read. Lookups scan every slot through the single RAM
//  read port, then decide. Create adds one further scan per candidate
//  reference tried. done pulses the cycle after the last step.
//  Reset: a clearing pass writes every slot, busy high.
//  The receiver cannot stall; busy holds off commands only.
// ----------------------------------------------------------------------------
module connection_reference_translation_table_core #(
    parameter int TABLE_ENTRIES = 64,
    parameter int OWNER_BITS    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [7:0]  owner_id,
    input  logic [5:0]  entry_index,
    input  logic        src_present,
    input  logic [23:0] src_ref,
    input  logic        dest_present,
    input  logic [23:0] dest_ref,
    input  logic        ref_start_we,
    input  logic [23:0] ref_start,
    output logic        done,
    output logic [2:0]  status,
    output logic [5:0]  hit_index,
    output logic [23:0] ref_out,
    output logic        ref_rewritten
);

    import crtt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int OW    = OWNER_BITS;
    // slot word: {valid, owner, real, patched, remote, stamp}
    localparam int STAMP_LO = 0;
    localparam int RM_LO    = STAMP_LO + STAMP_W;
    localparam int PT_LO    = RM_LO + REF_W;
    localparam int RL_LO    = PT_LO + REF_W;
    localparam int OWN_LO   = RL_LO + REF_W;
    localparam int VAL_BIT  = OWN_LO + OW;
    localparam int WORD_W   = VAL_BIT + 1;

    // RAM ports
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;

    crtt_slot_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W),
        .WIDTH  (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control state
    fsm_t              state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic              phase_alloc_reg, phase_alloc_next;
    logic              found_reg, found_next;
    logic              ffound_reg, ffound_next;
    logic              reuse_reg, reuse_next;
    logic [1:0]        wraps_reg, wraps_next;
    logic [REF_W-1:0]  nc_reg, nc_next;
    logic [STAMP_W-1:0] ctr_reg, ctr_next;
    logic              done_reg, done_next;

    // command and scan payload
    logic [2:0]        op_reg, op_next;
    logic [OW-1:0]     owner_reg, owner_next;
    logic [REF_W-1:0]  src_reg, src_next;
    logic              srcp_reg, srcp_next;
    logic [IDX_W-1:0]  eidx_reg, eidx_next;
    key_kind_t         kind_reg, kind_next;
    logic [REF_W-1:0]  key_reg, key_next;
    logic              byown_reg, byown_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0] best_age_reg, best_age_next;
    logic [WORD_W-1:0] best_word_reg, best_word_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]  tgt_idx_reg, tgt_idx_next;
    logic [WORD_W-1:0] tgt_word_reg, tgt_word_next;
    logic [REF_W-1:0]  cand_reg, cand_next;

    // results
    logic [2:0]        status_reg, status_next;
    logic [5:0]        hit_reg, hit_next;
    logic [REF_W-1:0]  rout_reg, rout_next;
    logic              rew_reg, rew_next;

    // input widening
    logic [OW+7:0]     own_ext;
    logic [IDX_W+5:0]  eidx_ext;
    logic              eidx_ok;
    assign own_ext  = {{OW{1'b0}}, owner_id};
    assign eidx_ext = {{IDX_W{1'b0}}, entry_index};
    assign eidx_ok  = eidx_ext < (IDX_W+6)'(TABLE_ENTRIES);

    // slot compare on returned RAM word
    logic               rd_valid;
    logic [REF_W-1:0]   rd_key;
    logic [STAMP_W-1:0] rd_age;
    logic               rd_match;
    logic               rd_better;

    always_comb
    begin
        rd_valid = rd_data[VAL_BIT];
        case (kind_reg)
            KEY_REAL:    rd_key = rd_data[RL_LO +: REF_W];
            KEY_PATCHED: rd_key = rd_data[PT_LO +: REF_W];
            KEY_REMOTE:  rd_key = rd_data[RM_LO +: REF_W];
            default:     rd_key = rd_data[RM_LO +: REF_W];
        endcase
        rd_age    = ctr_reg - rd_data[STAMP_LO +: STAMP_W];
        rd_match  = rd_valid && (rd_key == key_reg)
                    && (!byown_reg || (rd_data[OWN_LO +: OW] == owner_reg));
        // strict compare: on equal age the lower slot stays
        rd_better = rd_match && (!found_reg || (rd_age > best_age_reg));
    end

    always_comb
    begin
        logic              launch_scan;
        logic              launch_alloc;
        logic              alloc_first;
        logic              fin;
        logic [2:0]        f_status;
        logic [IDX_W-1:0]  f_hit;
        logic [REF_W-1:0]  f_rout;
        logic              f_rew;
        logic [REF_W-1:0]  adv;
        logic [1:0]        wraps_base;
        logic [WORD_W-1:0] wd;
        logic [IDX_W+5:0]  hit_ext;

        launch_scan  = 1'b0;
        launch_alloc = 1'b0;
        alloc_first  = 1'b0;
        fin          = 1'b0;
        f_status     = ST_NOT_FOUND;
        f_hit        = '0;
        f_rout       = '0;
        f_rew        = 1'b0;
        adv          = '0;
        wraps_base   = '0;
        wd           = tgt_word_reg;
        hit_ext      = '0;

        state_next       = state_reg;
        cnt_next         = cnt_reg;
        ridx_next        = ridx_reg;
        phase_alloc_next = phase_alloc_reg;
        found_next       = found_reg;
        ffound_next      = ffound_reg;
        reuse_next       = reuse_reg;
        wraps_next       = wraps_reg;
        nc_next          = nc_reg;
        ctr_next         = ctr_reg;
        done_next        = 1'b0;
        op_next          = op_reg;
        owner_next       = owner_reg;
        src_next         = src_reg;
        srcp_next        = srcp_reg;
        eidx_next        = eidx_reg;
        kind_next        = kind_reg;
        key_next         = key_reg;
        byown_next       = byown_reg;
        best_idx_next    = best_idx_reg;
        best_age_next    = best_age_reg;
        best_word_next   = best_word_reg;
        free_idx_next    = free_idx_reg;
        tgt_idx_next     = tgt_idx_reg;
        tgt_word_next    = tgt_word_reg;
        cand_next        = cand_reg;
        status_next      = status_reg;
        hit_next         = hit_reg;
        rout_next        = rout_reg;
        rew_next         = rew_reg;

        rd_en   = 1'b0;
        rd_addr = cnt_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = tgt_idx_reg;
        wr_data = '0;

        case (state_reg)
            FSM_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[IDX_W-1:0];
                wr_data  = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1))
                begin
                    cnt_next   = '0;
                    state_next = FSM_IDLE;
                end
            end

            FSM_IDLE:
            begin
                if (start)
                begin
                    op_next          = opcode;
                    owner_next       = own_ext[OW-1:0];
                    src_next         = src_ref;
                    srcp_next        = src_present;
                    eidx_next        = eidx_ext[IDX_W-1:0];
                    phase_alloc_next = 1'b0;
                    byown_next       = 1'b0;
                    key_next         = src_ref;
                    case (opcode)
                        OP_CREATE:
                        begin
                            kind_next  = KEY_REAL;
                            byown_next = 1'b1;
                            if (src_present)
                                launch_scan = 1'b1;
                            else
                            begin
                                fin      = 1'b1;
                                f_status = ST_MISSING;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (!src_present || !dest_present)
                            begin
                                fin      = 1'b1;
                                f_status = ST_MISSING;
                            end
                            else if (!eidx_ok)
                                fin = 1'b1;
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = eidx_ext[IDX_W-1:0];
                                state_next = FSM_UPD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            kind_next = KEY_PATCHED;
                            if (src_present)
                                launch_scan = 1'b1;
                            else
                            begin
                                fin      = 1'b1;
                                f_status = ST_MISSING;
                            end
                        end
                        OP_TO_OWNER:
                        begin
                            kind_next = KEY_PATCHED;
                            key_next  = dest_ref;
                            if (dest_present)
                                launch_scan = 1'b1;
                            else
                            begin
                                fin      = 1'b1;
                                f_status = ST_MISSING;
                            end
                        end
                        OP_TO_CORE:
                        begin
                            byown_next = 1'b1;
                            if (src_present)
                            begin
                                kind_next   = KEY_REAL;
                                launch_scan = 1'b1;
                            end
                            else if (dest_present)
                            begin
                                kind_next   = KEY_REMOTE;
                                key_next    = dest_ref;
                                launch_scan = 1'b1;
                            end
                            else
                            begin
                                fin      = 1'b1;
                                f_status = ST_MISSING;
                            end
                        end
                        OP_FIND:
                        begin
                            kind_next = KEY_REAL;
                            if (src_present)
                                launch_scan = 1'b1;
                            else
                            begin
                                fin      = 1'b1;
                                f_status = ST_MISSING;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            FSM_SCAN:
            begin
                if (cnt_reg != CNT_W'(TABLE_ENTRIES))
                begin
                    rd_en     = 1'b1;
                    ridx_next = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = FSM_DECIDE;
                end
                if (cnt_reg != '0)
                begin
                    if (rd_better)
                    begin
                        found_next     = 1'b1;
                        best_idx_next  = ridx_reg;
                        best_age_next  = rd_age;
                        best_word_next = rd_data;
                    end
                    if (!rd_valid && !ffound_reg)
                    begin
                        ffound_next   = 1'b1;
                        free_idx_next = ridx_reg;
                    end
                end
            end

            FSM_DECIDE:
            begin
                if (!phase_alloc_reg)
                begin
                    case (op_reg)
                        OP_CREATE:
                        begin
                            if (found_reg)
                            begin
                                reuse_next    = 1'b1;
                                tgt_idx_next  = best_idx_reg;
                                tgt_word_next = best_word_reg;
                                launch_alloc  = 1'b1;
                                alloc_first   = 1'b1;
                            end
                            else if (!ffound_reg)
                            begin
                                fin      = 1'b1;
                                f_status = ST_FULL;
                            end
                            else
                            begin
                                reuse_next   = 1'b0;
                                tgt_idx_next = free_idx_reg;
                                launch_alloc = 1'b1;
                                alloc_first  = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            fin = 1'b1;
                            if (found_reg)
                            begin
                                wd           = best_word_reg;
                                wd[VAL_BIT]  = 1'b0;
                                wr_en        = 1'b1;
                                wr_addr      = best_idx_reg;
                                wr_data      = wd;
                                f_status     = ST_FOUND;
                                f_hit        = best_idx_reg;
                            end
                        end
                        OP_TO_OWNER:
                        begin
                            fin = 1'b1;
                            if (found_reg)
                            begin
                                f_status = ST_FOUND;
                                f_hit    = best_idx_reg;
                                f_rout   = best_word_reg[RL_LO +: REF_W];
                                f_rew    = 1'b1;
                            end
                        end
                        OP_TO_CORE:
                        begin
                            fin = 1'b1;
                            if (found_reg)
                            begin
                                f_status = ST_FOUND;
                                f_hit    = best_idx_reg;
                                if (srcp_reg)
                                begin
                                    f_rout = best_word_reg[PT_LO +: REF_W];
                                    f_rew  = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                            if (found_reg)
                            begin
                                f_status = ST_FOUND;
                                f_hit    = best_idx_reg;
                            end
                        end
                    endcase
                end
                else if (!found_reg)
                begin
                    // candidate is free
                    fin     = 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = tgt_idx_reg;
                    f_hit   = tgt_idx_reg;
                    f_rout  = cand_reg;
                    if (reuse_reg)
                    begin
                        wd[PT_LO +: REF_W] = cand_reg;
                        wd[RM_LO +: REF_W] = '0;
                        f_status = ST_REUSED;
                    end
                    else
                    begin
                        wd = {1'b1, owner_reg, src_reg, cand_reg, {REF_W{1'b0}}, ctr_reg};
                        ctr_next = ctr_reg + 1'b1;
                        f_status = ST_CREATED;
                    end
                    wr_data = wd;
                end
                else if (wraps_reg == WRAP_LIMIT)
                begin
                    fin      = 1'b1;
                    f_status = ST_NO_REF;
                    if (reuse_reg)
                    begin
                        wd[VAL_BIT]        = 1'b0;
                        wd[RM_LO +: REF_W] = '0;
                        wr_en   = 1'b1;
                        wr_addr = tgt_idx_reg;
                        wr_data = wd;
                        f_hit   = tgt_idx_reg;
                    end
                end
                else
                begin
                    launch_alloc = 1'b1;
                end
            end

            FSM_UPD:
            begin
                fin = 1'b1;
                if (rd_valid)
                begin
                    wd                 = rd_data;
                    wd[RM_LO +: REF_W] = src_reg;
                    wr_en    = 1'b1;
                    wr_addr  = eidx_reg;
                    wr_data  = wd;
                    f_status = ST_FOUND;
                    f_hit    = eidx_reg;
                    f_rout   = src_reg;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase

        // next candidate; stepping onto the reserved value wraps to zero
        if (launch_alloc)
        begin
            wraps_base       = alloc_first ? 2'd0 : wraps_reg;
            cand_next        = nc_reg;
            adv              = nc_reg + 1'b1;
            kind_next        = KEY_PATCHED;
            key_next         = nc_reg;
            byown_next       = 1'b0;
            phase_alloc_next = 1'b1;
            launch_scan      = 1'b1;
            if (adv == REF_RESERVED)
            begin
                nc_next    = '0;
                wraps_next = wraps_base + 1'b1;
            end
            else
            begin
                nc_next    = adv;
                wraps_next = wraps_base;
            end
        end

        if (launch_scan)
        begin
            cnt_next    = '0;
            found_next  = 1'b0;
            ffound_next = 1'b0;
            state_next  = FSM_SCAN;
        end

        if (fin)
        begin
            hit_ext     = {6'b0, f_hit};
            status_next = f_status;
            hit_next    = hit_ext[5:0];
            rout_next   = f_rout;
            rew_next    = f_rew;
            done_next   = 1'b1;
            state_next  = FSM_IDLE;
        end

        if (ref_start_we)
        begin
            nc_next = (ref_start == REF_RESERVED) ? '0 : ref_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= FSM_CLEAR;
            cnt_reg         <= '0;
            phase_alloc_reg <= 1'b0;
            found_reg       <= 1'b0;
            ffound_reg      <= 1'b0;
            reuse_reg       <= 1'b0;
            wraps_reg       <= '0;
            nc_reg          <= REF_START_RESET;
            ctr_reg         <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            phase_alloc_reg <= phase_alloc_next;
            found_reg       <= found_next;
            ffound_reg      <= ffound_next;
            reuse_reg       <= reuse_next;
            wraps_reg       <= wraps_next;
            nc_reg          <= nc_next;
            ctr_reg         <= ctr_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg      <= ridx_next;
        op_reg        <= op_next;
        owner_reg     <= owner_next;
        src_reg       <= src_next;
        srcp_reg      <= srcp_next;
        eidx_reg      <= eidx_next;
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        byown_reg     <= byown_next;
        best_idx_reg  <= best_idx_next;
        best_age_reg  <= best_age_next;
        best_word_reg <= best_word_next;
        free_idx_reg  <= free_idx_next;
        tgt_idx_reg   <= tgt_idx_next;
        tgt_word_reg  <= tgt_word_next;
        cand_reg      <= cand_next;
        status_reg    <= status_next;
        hit_reg       <= hit_next;
        rout_reg      <= rout_next;
        rew_reg       <= rew_next;
    end

    assign busy          = (state_reg != FSM_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign hit_index     = hit_reg;
    assign ref_out       = rout_reg;
    assign ref_rewritten = rew_reg;

    // RAM writes only from the clearing pass or the closing step of a command
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == FSM_CLEAR || state_reg == FSM_DECIDE
                   || state_reg == FSM_UPD))
        else $error("slot write outside a write phase");

    // allocation gives up at the second wrap
    a_wrap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wraps_reg <= WRAP_LIMIT)
        else $error("wrap count past limit");

    // a newly assigned reference is never the reserved one
    a_no_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_CREATED || status_reg == ST_REUSED))
        |-> (rout_reg != REF_RESERVED))
        else $error("reserved reference handed out");

    // no result while a scan is still running
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == FSM_IDLE || $past(state_reg) == FSM_IDLE
                      || $past(state_reg) == FSM_DECIDE || $past(state_reg) == FSM_UPD))
        else $error("result strobe outside a closing step");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the connection reference translation table: drives
// command words, tracks table contents and reference allocation in a
// scoreboard, and checks every result word field by field.
// ----------------------------------------------------------------------------
module tb;
    import crtt_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  hit_index;
        logic [23:0] ref_out;
        logic        ref_rewritten;
    } xlate_word_t;

    class crtt_scoreboard;
        bit          valid [64];
        logic [7:0]  owner [64];
        logic [23:0] orig_ref [64];
        logic [23:0] patched [64];
        logic [23:0] remote [64];
        bit          has_remote [64];
        logic [31:0] stamp [64];
        logic [31:0] insert_cnt;
        logic [23:0] next_cand;
        xlate_word_t pending [$];
        int          errors;
        int          results;
        int          status_seen [8];

        function new();
            foreach (valid[i]) valid[i] = 0;
            insert_cnt = 0;
            next_cand  = REF_START_RESET;
            errors     = 0;
            results    = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void load_start(logic [23:0] v);
            next_cand = (v == REF_RESERVED) ? 24'd0 : v;
        endfunction

        function int used_slots();
            int n;
            n = 0;
            foreach (valid[i]) if (valid[i]) n++;
            return n;
        endfunction

        // earliest-inserted valid slot with matching key, -1 if none
        function int oldest_match(key_kind_t kind, logic [23:0] key, bit by_owner,
                                  logic [7:0] own);
            int          best;
            logic [31:0] best_age;
            logic [31:0] age;
            logic [23:0] k;
            best = -1;
            best_age = 0;
            for (int i = 0; i < 64; i++)
            begin
                k = (kind == KEY_REAL) ? orig_ref[i] :
                    (kind == KEY_PATCHED) ? patched[i] : remote[i];
                if (!valid[i] || k != key) continue;
                if (by_owner && owner[i] != own) continue;
                age = insert_cnt - stamp[i];
                if (best < 0 || age > best_age)
                begin
                    best = i;
                    best_age = age;
                end
            end
            return best;
        endfunction

        // wrapping counter, skips the reserved value and refs in use
        function bit alloc_ref(output logic [23:0] r);
            int          wraps;
            logic [23:0] c;
            wraps = 0;
            r = 0;
            do
            begin
                c = next_cand;
                next_cand = next_cand + 24'd1;
                if (next_cand == REF_RESERVED)
                begin
                    next_cand = 0;
                    wraps++;
                end
                if (oldest_match(KEY_PATCHED, c, 0, 8'd0) < 0)
                begin
                    r = c;
                    return 1;
                end
            end
            while (wraps != 2);
            return 0;
        endfunction

        function void note_command(logic [2:0] op, logic [7:0] own, logic [5:0] eidx,
                                   logic sp, logic [23:0] src, logic dp,
                                   logic [23:0] dst);
            xlate_word_t w;
            int          s;
            logic [23:0] r;
            w = '{status: ST_NOT_FOUND, hit_index: 6'd0, ref_out: 24'd0,
                  ref_rewritten: 1'b0};
            case (op)
                OP_CREATE:
                begin
                    if (!sp) w.status = ST_MISSING;
                    else
                    begin
                        s = oldest_match(KEY_REAL, src, 1, own);
                        if (s >= 0)
                        begin
                            // same owner and real ref: reuse slot with a fresh ref
                            w.hit_index = 6'(s);
                            remote[s] = 0;
                            if (alloc_ref(r))
                            begin
                                patched[s] = r;
                                w.status = ST_REUSED;
                                w.ref_out = r;
                            end
                            else
                            begin
                                valid[s] = 0;
                                w.status = ST_NO_REF;
                            end
                        end
                        else
                        begin
                            for (s = 0; s < 64 && valid[s]; s++) ;
                            if (s >= 64) w.status = ST_FULL;
                            else if (!alloc_ref(r)) w.status = ST_NO_REF;
                            else
                            begin
                                valid[s] = 1;
                                owner[s] = own;
                                orig_ref[s] = src;
                                patched[s] = r;
                                remote[s] = 0;
                                has_remote[s] = 0;
                                stamp[s] = insert_cnt;
                                insert_cnt++;
                                w.status = ST_CREATED;
                                w.hit_index = 6'(s);
                                w.ref_out = r;
                            end
                        end
                    end
                end
                OP_UPDATE:
                begin
                    if (!sp || !dp) w.status = ST_MISSING;
                    else if (valid[eidx])
                    begin
                        remote[eidx] = src;
                        has_remote[eidx] = 1;
                        w.status = ST_FOUND;
                        w.hit_index = eidx;
                        w.ref_out = src;
                    end
                end
                OP_REMOVE:
                begin
                    if (!sp) w.status = ST_MISSING;
                    else
                    begin
                        s = oldest_match(KEY_PATCHED, src, 0, 8'd0);
                        if (s >= 0)
                        begin
                            valid[s] = 0;
                            w.status = ST_FOUND;
                            w.hit_index = 6'(s);
                        end
                    end
                end
                OP_TO_OWNER:
                begin
                    if (!dp) w.status = ST_MISSING;
                    else
                    begin
                        s = oldest_match(KEY_PATCHED, dst, 0, 8'd0);
                        if (s >= 0)
                        begin
                            w.status = ST_FOUND;
                            w.hit_index = 6'(s);
                            w.ref_out = orig_ref[s];
                            w.ref_rewritten = 1;
                        end
                    end
                end
                OP_TO_CORE:
                begin
                    if (sp)
                    begin
                        s = oldest_match(KEY_REAL, src, 1, own);
                        if (s >= 0)
                        begin
                            w.status = ST_FOUND;
                            w.hit_index = 6'(s);
                            w.ref_out = patched[s];
                            w.ref_rewritten = 1;
                        end
                    end
                    else if (dp)
                    begin
                        // remote match ignores whether a remote was ever recorded
                        s = oldest_match(KEY_REMOTE, dst, 1, own);
                        if (s >= 0)
                        begin
                            w.status = ST_FOUND;
                            w.hit_index = 6'(s);
                        end
                    end
                    else w.status = ST_MISSING;
                end
                OP_FIND:
                begin
                    if (!sp) w.status = ST_MISSING;
                    else
                    begin
                        s = oldest_match(KEY_REAL, src, 0, 8'd0);
                        if (s >= 0)
                        begin
                            w.status = ST_FOUND;
                            w.hit_index = 6'(s);
                        end
                    end
                end
                default: ;
            endcase
            pending.push_back(w);
        endfunction

        function void check_result(xlate_word_t got);
            xlate_word_t want;
            results++;
            status_seen[got.status]++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word status=%0d hit=%0d ref=%h rw=%0d",
                         $time, got.status, got.hit_index, got.ref_out,
                         got.ref_rewritten);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status,
                         got.status);
                errors++;
            end
            if (got.hit_index !== want.hit_index)
            begin
                $display("%0t: hit_index expected %0d actual %0d", $time,
                         want.hit_index, got.hit_index);
                errors++;
            end
            if (got.ref_out !== want.ref_out)
            begin
                $display("%0t: ref_out expected %h actual %h", $time, want.ref_out,
                         got.ref_out);
                errors++;
            end
            if (got.ref_rewritten !== want.ref_rewritten)
            begin
                $display("%0t: ref_rewritten expected %0d actual %0d", $time,
                         want.ref_rewritten, got.ref_rewritten);
                errors++;
            end
        endfunction
    endclass

    // opcodes the block leaves unused
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  opcode = 0;
    logic [7:0]  owner_id = 0;
    logic [5:0]  entry_index = 0;
    logic        src_present = 0;
    logic [23:0] src_ref = 0;
    logic        dest_present = 0;
    logic [23:0] dest_ref = 0;
    logic        ref_start_we = 0;
    logic [23:0] ref_start = 0;
    logic        done;
    logic [2:0]  status;
    logic [5:0]  hit_index;
    logic [23:0] ref_out;
    logic        ref_rewritten;

    crtt_scoreboard sb = new();
    int accepted = 0;
    int gap_pct = 0;     // chance in percent of an idle gap before a command

    always #10 clk = ~clk;

    connection_reference_translation_table_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .owner_id(owner_id), .entry_index(entry_index),
        .src_present(src_present), .src_ref(src_ref),
        .dest_present(dest_present), .dest_ref(dest_ref),
        .ref_start_we(ref_start_we), .ref_start(ref_start),
        .done(done), .status(status), .hit_index(hit_index),
        .ref_out(ref_out), .ref_rewritten(ref_rewritten)
    );

    // monitor: commands are predicted at acceptance, results checked on done
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            sb.note_command(opcode, owner_id, entry_index, src_present, src_ref,
                            dest_present, dest_ref);
            accepted++;
        end
        if (rst_n && done)
            sb.check_result('{status, hit_index, ref_out, ref_rewritten});
    end

    initial
    begin
        #200_000_000;
        $display("timeout waiting for the block");
        $display("CHECK FAILED");
        $finish;
    end

    // one command word; holds start until the block takes it
    task automatic issue(logic [2:0] op, logic [7:0] own, logic [5:0] eidx,
                         logic sp, logic [23:0] src, logic dp, logic [23:0] dst);
        int n;
        if ($urandom_range(99) < gap_pct) repeat ($urandom_range(80, 1)) @(negedge clk);
        opcode = op;
        owner_id = own;
        entry_index = eidx;
        src_present = sp;
        src_ref = src;
        dest_present = dp;
        dest_ref = dst;
        start = 1;
        n = accepted;
        do @(negedge clk); while (accepted == n);
        start = 0;
    endtask

    // write the start register once the table is quiet
    task automatic set_ref_start(logic [23:0] v);
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        ref_start_we = 1;
        ref_start = v;
        @(negedge clk);
        ref_start_we = 0;
        sb.load_start(v);
    endtask

    function automatic int any_live_slot();
        int s;
        if (sb.used_slots() == 0) return -1;
        do s = $urandom_range(63); while (!sb.valid[s]);
        return s;
    endfunction

    // random command biased toward hitting live entries
    task automatic random_command(int create_bias);
        logic [2:0]  op;
        logic [7:0]  own;
        logic [23:0] src, dst;
        logic        sp, dp;
        int          s, pick;
        pick = $urandom_range(99);
        if (pick < create_bias) op = OP_CREATE;
        else if (pick < create_bias + 10) op = OP_UPDATE;
        else if (pick < create_bias + 25) op = OP_REMOVE;
        else if (pick < create_bias + 45) op = OP_TO_OWNER;
        else if (pick < create_bias + 70) op = OP_TO_CORE;
        else if (pick < 98) op = OP_FIND;
        else op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
        s = any_live_slot();
        // small owner and ref pools make duplicates and reuse common
        own = ($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom);
        src = ($urandom_range(9) < 6) ? 24'($urandom_range(15)) : 24'($urandom);
        dst = 24'($urandom);
        if (s >= 0 && $urandom_range(9) < 7)
        begin
            own = sb.owner[s];
            case (op)
                OP_REMOVE: src = sb.patched[s];
                OP_TO_OWNER: dst = sb.patched[s];
                OP_CREATE, OP_TO_CORE, OP_FIND: src = sb.orig_ref[s];
                default: ;
            endcase
            if (op == OP_TO_CORE) dst = sb.remote[s];
        end
        sp = $urandom_range(9) != 0;
        dp = $urandom_range(9) != 0;
        if (op == OP_TO_CORE && $urandom_range(1)) sp = 0;
        issue(op, own, 6'($urandom), sp, src, dp, dst);
    endtask

    initial
    begin
        int s;
        repeat (4) @(negedge clk);
        rst_n = 1;
        while (busy !== 1'b0) @(negedge clk);   // clearing pass

        // directed: every opcode, missing refs, extremes, reuse, wrap
        issue(OP_CREATE, 8'h00, 6'd0, 0, 24'h000001, 0, 24'h0);
        issue(OP_CREATE, 8'h00, 6'd0, 1, 24'h000000, 0, 24'h0);
        issue(OP_CREATE, 8'hFF, 6'd0, 1, 24'hFFFFFF, 1, 24'hFFFFFF);
        issue(OP_CREATE, 8'h01, 6'd0, 1, 24'h000000, 0, 24'h0);
        issue(OP_CREATE, 8'hFF, 6'd0, 1, 24'hFFFFFF, 0, 24'h0);     // reuse
        issue(OP_UPDATE, 8'h00, 6'd0, 1, 24'hABCDEF, 0, 24'h0);     // missing
        issue(OP_UPDATE, 8'h00, 6'd0, 1, 24'hABCDEF, 1, 24'h000001);
        issue(OP_UPDATE, 8'h00, 6'd63, 1, 24'h123456, 1, 24'h000001); // empty slot
        issue(OP_TO_OWNER, 8'h00, 6'd0, 0, 24'h0, 0, 24'h050000);
        issue(OP_TO_OWNER, 8'h00, 6'd0, 0, 24'h0, 1, 24'h050000);
        issue(OP_TO_OWNER, 8'h00, 6'd0, 0, 24'h0, 1, 24'hFFFFFF);
        issue(OP_TO_CORE, 8'h00, 6'd0, 1, 24'h000000, 1, 24'h0);
        issue(OP_TO_CORE, 8'h00, 6'd0, 0, 24'h0, 1, 24'hABCDEF);
        issue(OP_TO_CORE, 8'h01, 6'd0, 0, 24'h0, 1, 24'h000000);   // remote never set
        issue(OP_TO_CORE, 8'h02, 6'd0, 0, 24'h0, 0, 24'h0);
        issue(OP_FIND, 8'h77, 6'd0, 1, 24'h000000, 0, 24'h0);
        issue(OP_FIND, 8'h00, 6'd0, 0, 24'h000000, 0, 24'h0);
        issue(OP_REMOVE, 8'h00, 6'd0, 0, 24'h050000, 0, 24'h0);
        issue(OP_REMOVE, 8'h00, 6'd0, 1, 24'h050000, 0, 24'h0);
        issue(OP_REMOVE, 8'h00, 6'd0, 1, 24'h050000, 0, 24'h0);
        issue(OP_SPARE_A, 8'h00, 6'd0, 1, 24'h050001, 1, 24'h0);
        issue(OP_SPARE_B, 8'hFF, 6'h3F, 1, 24'hFFFFFF, 1, 24'hFFFFFF);
        set_ref_start(24'hFFFFFE);                 // counter wraps past reserved
        issue(OP_CREATE, 8'h05, 6'd0, 1, 24'h000100, 0, 24'h0);
        issue(OP_CREATE, 8'h05, 6'd0, 1, 24'h000101, 0, 24'h0);
        set_ref_start(24'hFFFFFF);                 // reserved value loads zero
        issue(OP_CREATE, 8'h05, 6'd0, 1, 24'h000100, 0, 24'h0);

        // random phases: settings and sender gaps vary per phase; phase two
        // leans on create to fill the table and see the full status
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    set_ref_start(24'h000000);
                    gap_pct = 0;
                end
                1:
                begin
                    set_ref_start(24'hFFFFFD);
                    gap_pct = 65;
                end
                2:
                begin
                    set_ref_start(24'($urandom_range(24'hFFFFFE)));
                    gap_pct = 10;
                end
                3:
                begin
                    // aim the counter at references in use so it must skip
                    s = any_live_slot();
                    set_ref_start(s >= 0 ? sb.patched[s] : 24'h0);
                    gap_pct = 65;
                end
                default:
                begin
                    set_ref_start(REF_START_RESET);
                    gap_pct = 0;
                end
            endcase
            for (int i = 0; i < 275; i++)
                random_command(p == 2 ? 60 : (sb.used_slots() > 48 ? 10 : 25));
        end

        while (sb.pending.size() != 0) @(negedge clk);
        repeat (150) @(negedge clk);
        $display("%0d commands, %0d results; created %0d reused %0d found %0d",
                 accepted, sb.results, sb.status_seen[ST_CREATED],
                 sb.status_seen[ST_REUSED], sb.status_seen[ST_FOUND]);
        $display("not found %0d, missing ref %0d, table full %0d, mismatches %0d",
                 sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_MISSING],
                 sb.status_seen[ST_FULL], sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
